/* sv/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the servo sweep PWM controller
// Holds the register indexes, angle and pulse constants, and the
// angle-to-compare conversion used by the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    // Width of the time base by default.
    localparam int TimeBitsDefault = 32;

    // Configuration port layout.
    localparam int CfgIndexBits = 2;
    localparam int CfgDataBits  = 16;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_RESYNC_GAP    = 2'd0,
        CFG_SLOW_INTERVAL = 2'd1,
        CFG_FAST_INTERVAL = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [15:0] ResyncGapReset    = 16'd200;
    localparam logic [7:0]  SlowIntervalReset = 8'd15;
    localparam logic [7:0]  FastIntervalReset = 8'd10;

    // Angle limits and reset state.
    localparam logic [7:0] MaxAngle   = 8'd180;
    localparam logic [7:0] AngleReset = 8'd90;

    // Opcodes of an input transaction.
    typedef enum logic {
        OP_SWEEP_TICK = 1'b0,
        OP_SET_ANGLE  = 1'b1
    } opcode_t;

    // Pulse mapping: 25 + angle*100/180 = 25 + (5*angle)/9.
    localparam logic [6:0]  PulseBase = 7'd25;
    // 2^16/9 rounded up; exact floor for 5*angle up to 900.
    localparam logic [12:0] RecipNine = 13'd7282;

    // Compare value for an angle in 0..180.
    function automatic logic [6:0] pulse_compare_of(input logic [7:0] ang);
        logic [9:0]  five_a;
        logic [22:0] prod;
        begin
            five_a = {ang, 2'b00} + {2'b00, ang};
            prod   = {13'd0, five_a} * {10'd0, RecipNine};
            return PulseBase + prod[22:16];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/servo_sweep_pwm_controller_top.sv */
// ----------------------------------------------------------------------------
// servo_sweep_pwm_controller_top: servo sweep controller with PWM compare
// Result path: the state update stage, then the compare-value stage, each
// registered. Throughput: one transaction per cycle while the result channel
// does not stall, as angle, direction and time base update on every accept.
// Reset (aresetn low, synchronous): angle 90, direction up, time base
// unsynchronized, registers back to 200/15/10, pipeline emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_sweep_pwm_controller_top
    import ssp_pkg::*;
#(
    parameter int TIME_BITS = TimeBitsDefault
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    // Configuration write channel.
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CfgIndexBits-1:0] cfg_index,
    input  wire logic [CfgDataBits-1:0]  cfg_data,

    // Input channel.
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_opcode,
    input  wire logic [TIME_BITS-1:0]    s_now_ms,
    input  wire logic signed [7:0]       s_speed_level,
    input  wire logic                    s_sweep_enable,
    input  wire logic [7:0]              s_target_angle,

    // Result channel.
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [6:0]                   m_pulse_compare,
    output logic [7:0]                   m_angle_deg,
    output logic                         m_pulse_written
);

    // Configuration registers.
    logic [15:0] resync_gap_reg;
    logic [7:0]  slow_interval_reg;
    logic [7:0]  fast_interval_reg;

    // Controller state.
    logic [7:0]           angle_reg,    angle_next;
    logic                 sweep_up_reg, sweep_up_next;
    logic [TIME_BITS-1:0] last_reg,     last_next;

    // First stage: angle after the transaction and the written flag.
    logic       s1_valid_reg;
    logic [7:0] s1_angle_reg;
    logic       s1_written_reg;
    logic       written_next;

    // Output stage.
    logic       m_valid_reg;
    logic [6:0] m_compare_reg;
    logic [7:0] m_angle_reg;
    logic       m_written_reg;

    logic s_accept;
    logic s1_advance;

    // Handshakes: the output register frees space, the first stage follows.
    assign cfg_ready  = 1'b1;
    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resync_gap_reg    <= ResyncGapReset;
            slow_interval_reg <= SlowIntervalReset;
            fast_interval_reg <= FastIntervalReset;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RESYNC_GAP:    resync_gap_reg    <= cfg_data;
                CFG_SLOW_INTERVAL: slow_interval_reg <= cfg_data[7:0];
                CFG_FAST_INTERVAL: fast_interval_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sweep and set-angle update.
    logic                 stopped;
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] interval;
    logic [7:0]           step;
    logic [8:0]           sum_up;

    always_comb begin
        stopped  = !s_sweep_enable || s_speed_level[7] || (s_speed_level == 8'sd0);
        gap      = s_now_ms - last_reg;
        interval = (s_speed_level == 8'sd1)
                 ? TIME_BITS'(slow_interval_reg) : TIME_BITS'(fast_interval_reg);
        priority if (s_speed_level == 8'sd3) begin
            step = 8'd2;
        end else if (s_speed_level > 8'sd3) begin
            step = 8'd4;
        end else begin
            step = 8'd1;
        end
        sum_up = {1'b0, angle_reg} + {1'b0, step};

        angle_next    = angle_reg;
        sweep_up_next = sweep_up_reg;
        last_next     = last_reg;
        written_next  = 1'b0;

        if (opcode_t'(s_opcode) == OP_SET_ANGLE) begin
            angle_next   = (s_target_angle > MaxAngle) ? MaxAngle : s_target_angle;
            written_next = 1'b1;
        end else if (stopped) begin
            last_next = '0;
        end else if ((last_reg == '0) || (gap > TIME_BITS'(resync_gap_reg))) begin
            last_next = s_now_ms;
        end else if (gap >= interval) begin
            last_next    = s_now_ms;
            written_next = 1'b1;
            if (sweep_up_reg) begin
                if (sum_up >= {1'b0, MaxAngle}) begin
                    angle_next    = MaxAngle;
                    sweep_up_next = 1'b0;
                end else begin
                    angle_next = sum_up[7:0];
                end
            end else begin
                if (angle_reg <= step) begin
                    angle_next    = '0;
                    sweep_up_next = 1'b1;
                end else begin
                    angle_next = angle_reg - step;
                end
            end
        end
    end

    // State registers, updated once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg    <= AngleReset;
            sweep_up_reg <= 1'b1;
            last_reg     <= '0;
        end else if (s_accept) begin
            angle_reg    <= angle_next;
            sweep_up_reg <= sweep_up_next;
            last_reg     <= last_next;
        end
    end

    // First pipeline stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_angle_reg   <= angle_next;
            s1_written_reg <= written_next;
        end
    end

    // Output stage with the compare value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_compare_reg <= pulse_compare_of(s1_angle_reg);
            m_angle_reg   <= s1_angle_reg;
            m_written_reg <= s1_written_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pulse_compare = m_compare_reg;
    assign m_angle_deg     = m_angle_reg;
    assign m_pulse_written = m_written_reg;

    // The stored angle never leaves its range.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_reg <= MaxAngle)
        else $error("angle state out of range");

    // A result leaving the block carries a compare value in range.
    a_compare_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_compare_reg >= PulseBase) && (m_compare_reg <= 7'd125))
        else $error("compare value out of range");

    // A stalled first stage keeps its transaction.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg && $stable(s1_angle_reg))
        else $error("first stage lost a stalled transaction");

    // An accepted transaction that writes nothing leaves the angle unchanged.
    a_written_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !written_next) |=> (angle_reg == $past(angle_reg)))
        else $error("angle changed without a write");

endmodule

`default_nettype wire

/* test/tb_servo_sweep_pwm_controller_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_sweep_pwm_controller_top: self-checking bench for the servo sweep
// Drives set-angle commands and sweep ticks through the input channel and
// predicts every result with a cycle-free model of angle, direction and
// time base. Covers directed corner cases and random tick traffic under
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_servo_sweep_pwm_controller_top;
    import ssp_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int PRINT_LIMIT = 60;

    typedef struct {
        opcode_t           op;
        logic [31:0]       now;
        logic signed [7:0] speed;
        logic              enable;
        logic [7:0]        target;
    } servo_cmd_t;

    typedef struct {
        logic [6:0] compare;
        logic [7:0] angle;
        logic       written;
    } pulse_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [CfgDataBits-1:0]  cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_opcode;
    logic [31:0]             s_now_ms;
    logic signed [7:0]       s_speed_level;
    logic                    s_sweep_enable;
    logic [7:0]              s_target_angle;
    logic                    m_valid;
    logic                    m_ready;
    logic [6:0]              m_pulse_compare;
    logic [7:0]              m_angle_deg;
    logic                    m_pulse_written;

    // Predicted servo state and register copies.
    logic [7:0]  srv_angle;
    logic        srv_up;
    logic [31:0] srv_last_ms;
    logic [15:0] reg_resync_gap;
    logic [7:0]  reg_slow_interval;
    logic [7:0]  reg_fast_interval;

    pulse_result_t pending_pulses[$];

    int          error_count;
    int          commands_sent;
    int          results_seen;
    int          steps_seen;
    int          cfg_writes;
    int          send_gap_max;
    int          recv_stall_max;
    bit          hold_request;
    int          stall_cycles;
    logic [31:0] sweep_clock_ms;

    servo_sweep_pwm_controller_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_now_ms        (s_now_ms),
        .s_speed_level   (s_speed_level),
        .s_sweep_enable  (s_sweep_enable),
        .s_target_angle  (s_target_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pulse_compare (m_pulse_compare),
        .m_angle_deg     (m_angle_deg),
        .m_pulse_written (m_pulse_written)
    );

    // Free-running 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advance the predicted state by one command and return its result.
    function automatic pulse_result_t step_servo(servo_cmd_t c);
        pulse_result_t r;
        logic [31:0]   gap;
        logic [7:0]    interval;
        int            step;
        int            next_angle;
        r.written = 1'b0;
        if (c.op == OP_SET_ANGLE) begin
            srv_angle = (c.target > MaxAngle) ? MaxAngle : c.target;
            r.written = 1'b1;
        end else if (!c.enable || c.speed <= 0) begin
            srv_last_ms = '0;
        end else begin
            gap = c.now - srv_last_ms;
            if (srv_last_ms == 32'd0 || gap > {16'd0, reg_resync_gap}) begin
                srv_last_ms = c.now;
            end else begin
                interval = (c.speed == 1) ? reg_slow_interval : reg_fast_interval;
                step = (c.speed == 3) ? 2 : (c.speed >= 4) ? 4 : 1;
                if (gap >= {24'd0, interval}) begin
                    srv_last_ms = c.now;
                    next_angle = int'(srv_angle) + (srv_up ? step : -step);
                    if (next_angle >= int'(MaxAngle)) begin
                        next_angle = int'(MaxAngle);
                        srv_up = 1'b0;
                    end else if (next_angle <= 0) begin
                        next_angle = 0;
                        srv_up = 1'b1;
                    end
                    srv_angle = 8'(next_angle);
                    r.written = 1'b1;
                end
            end
        end
        r.angle   = srv_angle;
        r.compare = 7'(int'(PulseBase) + (int'(srv_angle) * 100) / int'(MaxAngle));
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // Send one command: optional idle gap, then hold valid until accepted.
    task automatic send_command(servo_cmd_t c);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= c.op;
        s_now_ms       <= c.now;
        s_speed_level  <= c.speed;
        s_sweep_enable <= c.enable;
        s_target_angle <= c.target;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_pulses.push_back(step_servo(c));
        commands_sent++;
    endtask

    task automatic send_tick(logic [31:0] now, logic signed [7:0] speed, logic enable);
        servo_cmd_t c;
        c.op     = OP_SWEEP_TICK;
        c.now    = now;
        c.speed  = speed;
        c.enable = enable;
        c.target = 8'($urandom);
        send_command(c);
    endtask

    // Set-angle command; the unused fields carry random values.
    task automatic send_set(logic [7:0] target);
        servo_cmd_t c;
        c.op     = OP_SET_ANGLE;
        c.now    = $urandom;
        c.speed  = 8'($urandom);
        c.enable = 1'($urandom);
        c.target = target;
        send_command(c);
    endtask

    // Stop offering commands until every pending result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_RESYNC_GAP:    reg_resync_gap    = value;
            CFG_SLOW_INTERVAL: reg_slow_interval = value[7:0];
            CFG_FAST_INTERVAL: reg_fast_interval = value[7:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(logic [15:0] gap, logic [7:0] slow, logic [7:0] fast);
        drain_results();
        write_reg(CFG_RESYNC_GAP, gap);
        write_reg(CFG_SLOW_INTERVAL, {8'd0, slow});
        write_reg(CFG_FAST_INTERVAL, {8'd0, fast});
    endtask

    // Time step between ticks, biased around the current intervals and gap.
    function automatic logic [31:0] next_tick_gap();
        int unsigned span;
        int          roll;
        span = ((reg_slow_interval > reg_fast_interval) ?
                reg_slow_interval : reg_fast_interval) + 2;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, span);
        else if (roll < 85)
            return $urandom_range(0, int'(reg_resync_gap) + 2);
        else if (roll < 95)
            return int'(reg_resync_gap) + $urandom_range(1, 500);
        return $urandom;
    endfunction

    // Mostly well-formed ticks on a running clock, plus stops and set commands.
    task automatic run_random_traffic(int count, bit vary_idle);
        servo_cmd_t c;
        int         roll;
        sweep_clock_ms = $urandom;
        for (int i = 0; i < count; i++) begin
            if (vary_idle && (i % 50 == 0)) begin
                send_gap_max   = 5 * $urandom_range(0, 1);
                recv_stall_max = 5 * $urandom_range(0, 1);
            end
            c.target = 8'($urandom);
            if ($urandom_range(0, 99) < 8) begin
                c.op     = OP_SET_ANGLE;
                c.now    = $urandom;
                c.speed  = 8'($urandom);
                c.enable = 1'($urandom);
            end else begin
                sweep_clock_ms = sweep_clock_ms + next_tick_gap();
                c.op     = OP_SWEEP_TICK;
                c.now    = sweep_clock_ms;
                c.enable = ($urandom_range(0, 19) != 0);
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    c.speed = 8'($urandom_range(1, 4));
                else if (roll < 90)
                    c.speed = 8'($urandom_range(5, 127));
                else
                    c.speed = 8'($urandom_range(0, 255));
            end
            send_command(c);
        end
    endtask

    // Corner cases under the reset register values.
    task automatic test_directed_edges();
        send_gap_max   = 2;
        recv_stall_max = 2;
        send_set(8'd255);
        send_set(8'd0);
        send_set(8'd180);
        // Syncing at time zero must leave the time base unsynchronized.
        send_tick(32'd0, 8'sd1, 1'b1);
        send_tick(32'd100, 8'sd1, 1'b1);
        send_tick(32'd110, 8'sd1, 1'b1);
        send_tick(32'd115, 8'sd1, 1'b1);
        send_tick(32'd125, 8'sd2, 1'b1);
        send_tick(32'd135, 8'sd3, 1'b1);
        send_tick(32'd145, 8'sd127, 1'b1);
        send_tick(32'd155, 8'sd4, 1'b1);
        // Disabled sweep and non-positive speeds clear the sync.
        send_tick(32'd165, 8'sd4, 1'b0);
        send_tick(32'd170, 8'sd4, 1'b1);
        send_tick(32'd180, -8'sd128, 1'b1);
        send_tick(32'd190, 8'sd0, 1'b1);
        // Gap above the resync limit, then exactly at it.
        send_tick(32'd200, 8'sd2, 1'b1);
        send_tick(32'd600, 8'sd2, 1'b1);
        send_tick(32'd800, 8'sd2, 1'b1);
        // Clamp at zero and turn upward.
        send_set(8'd3);
        send_tick(32'd810, 8'sd4, 1'b1);
        send_tick(32'd820, 8'sd4, 1'b1);
        // Time difference across the 32-bit wrap.
        send_tick(32'hFFFF_FFF8, 8'sd2, 1'b1);
        send_tick(32'h0000_0005, 8'sd2, 1'b1);
        send_set(8'h7F);
        drain_results();
    endtask

    // Long output stall while commands keep coming, so the input backs up.
    task automatic test_backpressure();
        drain_results();
        send_gap_max   = 0;
        recv_stall_max = 0;
        hold_request   = 1'b1;
        run_random_traffic(48, 1'b0);
        drain_results();
    endtask

    task automatic test_high_register_limits();
        apply_settings(16'hFFFF, 8'd255, 8'd255);
        run_random_traffic(300, 1'b1);
    endtask

    task automatic test_low_register_limits();
        apply_settings(16'd1, 8'd1, 8'd1);
        run_random_traffic(300, 1'b1);
    endtask

    task automatic test_zero_registers();
        apply_settings(16'd0, 8'd0, 8'd0);
        run_random_traffic(300, 1'b1);
    endtask

    task automatic test_random_registers();
        for (int k = 0; k < 2; k++) begin
            apply_settings(16'($urandom_range(1, 400)), 8'($urandom_range(1, 255)),
                           8'($urandom_range(1, 255)));
            run_random_traffic(150, 1'b1);
        end
        apply_settings(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 40)),
                       8'($urandom_range(1, 40)));
        run_random_traffic(300, 1'b1);
    endtask

    task automatic test_default_registers();
        apply_settings(ResyncGapReset, SlowIntervalReset, FastIntervalReset);
        // Writes to the spare index change nothing.
        write_reg(CFG_UNUSED, 16'($urandom));
        run_random_traffic(300, 1'b1);
        drain_results();
    endtask

    // Result side: random stalls, one long hold on request, field checks.
    initial begin
        int            stall;
        pulse_result_t want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                stall = $urandom_range(0, recv_stall_max);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            results_seen++;
            if (pending_pulses.size() == 0) begin
                report_mismatch("unexpected result, angle", m_angle_deg, -1);
            end else begin
                want = pending_pulses.pop_front();
                if (m_pulse_compare !== want.compare)
                    report_mismatch("pulse_compare", m_pulse_compare, want.compare);
                if (m_angle_deg !== want.angle)
                    report_mismatch("angle_deg", m_angle_deg, want.angle);
                if (m_pulse_written !== want.written)
                    report_mismatch("pulse_written", m_pulse_written, want.written);
                if (want.written)
                    steps_seen++;
            end
        end
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("tb_servo_sweep_pwm_controller_top: errors");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_RESYNC_GAP;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_opcode          = OP_SWEEP_TICK;
        s_now_ms          = '0;
        s_speed_level     = '0;
        s_sweep_enable    = 1'b0;
        s_target_angle    = '0;
        srv_angle         = AngleReset;
        srv_up            = 1'b1;
        srv_last_ms       = '0;
        reg_resync_gap    = ResyncGapReset;
        reg_slow_interval = SlowIntervalReset;
        reg_fast_interval = FastIntervalReset;
        error_count       = 0;
        commands_sent     = 0;
        results_seen      = 0;
        steps_seen        = 0;
        cfg_writes        = 0;
        send_gap_max      = 0;
        recv_stall_max    = 0;
        hold_request      = 1'b0;
        stall_cycles      = 0;
        sweep_clock_ms    = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_backpressure();
        test_high_register_limits();
        test_low_register_limits();
        test_zero_registers();
        test_random_registers();
        test_default_registers();

        // Let the pipeline settle, then look for anything still owed.
        repeat (8) @(posedge aclk);
        if (pending_pulses.size() != 0)
            report_mismatch("results never delivered", 0, pending_pulses.size());

        $display("Run covered %0d commands, %0d results (%0d angle updates), %0d register writes,",
                 commands_sent, results_seen, steps_seen, cfg_writes);
        $display("spanning zero, minimum, maximum and random settings plus a long output hold.");
        if (error_count == 0) begin
            $display("tb_servo_sweep_pwm_controller_top: clean");
        end else begin
            $display("tb_servo_sweep_pwm_controller_top: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ssp_pkg.sv
sv/servo_sweep_pwm_controller_top.sv
test/tb_servo_sweep_pwm_controller_top.sv
